// ===== hw/rtl/wide_multiply_divide_unit_assert.svh =====
// Assertion macros shared by the multiply/divide unit.
`ifndef WIDE_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH
`define WIDE_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WMDU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("wmdu check");
`define WMDU_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("wmdu reset check");
`else
`define WMDU_ASSERT(label, prop)
`define WMDU_ASSERT_RST(label, prop)
`endif
`endif

// ===== hw/rtl/wmdu_pkg.sv =====
// Shared constants of the multiply/divide unit.
package wmdu_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned KindW = 2;
  localparam logic [KindW-1:0] KIND_MULU = 2'd0;
  localparam logic [KindW-1:0] KIND_MULS = 2'd1;
  localparam logic [KindW-1:0] KIND_DIVS = 2'd2;
  localparam logic [KindW-1:0] KIND_DIVU = 2'd3;
  localparam logic [DataW-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
endpackage

// ===== hw/rtl/wide_multiply_divide_unit.sv =====
// Pipelined 64-bit multiply/divide unit, top level.
//
// Input channel: in_valid, in_stall, in_kind, in_operand_a, in_operand_b.
// Result channel: out_valid, out_stall, out_low_word, out_high_word.
// An item moves when valid is high and stall is low at a rising clock edge.
// Kinds: unsigned multiply, signed multiply, signed divide, unsigned divide.
// Multiplies give the 128-bit product; divides give quotient and remainder.
// A zero divisor and the signed overflow case divide by one.
//
// An item passes through these stages after acceptance: one stage forms
// the four 32x32 partial products, the signed product correction and the
// operand magnitudes, one stage adds the partial products, 64 stages each
// retire one quotient bit with a 65-bit compare and subtract, and the
// output register fixes the signs.
// Throughput is one item per cycle unless stalled; kinds share one path.
// Reset clears all valid bits; payload is not reset.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated, and it resumes on release.
`include "wide_multiply_divide_unit_assert.svh"
module wide_multiply_divide_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wmdu_pkg::KindW-1:0]     in_kind,
  input  logic [wmdu_pkg::DataW-1:0]     in_operand_a,
  input  logic [wmdu_pkg::DataW-1:0]     in_operand_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wmdu_pkg::DataW-1:0]     out_low_word,
  output logic [wmdu_pkg::DataW-1:0]     out_high_word
);
  localparam int unsigned W     = wmdu_pkg::DataW;
  localparam int unsigned H     = wmdu_pkg::HalfW;
  localparam int unsigned Steps = wmdu_pkg::DataW;

  logic adv;
  logic out_valid_r;
  logic [W-1:0] out_lo_r, out_hi_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_low_word  = out_lo_r;
  assign out_high_word = out_hi_r;

  // Stage 0: partial products and divide operand preparation.
  logic         s0_vld_r;
  logic         s0_div_r, s0_negq_r, s0_negr_r;
  logic [W-1:0] s0_ma_r, s0_mb_r, s0_corr_r;
  logic [W-1:0] s0_p00_r, s0_p01_r, s0_p10_r, s0_p11_r;

  logic         a_neg, b_neg, is_div, is_sdiv, is_muls, special;
  logic [W-1:0] ma_nxt, mb_nxt, corr_nxt;

  always_comb begin
    is_div  = (in_kind == wmdu_pkg::KIND_DIVS) || (in_kind == wmdu_pkg::KIND_DIVU);
    is_sdiv = (in_kind == wmdu_pkg::KIND_DIVS);
    is_muls = (in_kind == wmdu_pkg::KIND_MULS);
    a_neg   = is_sdiv && in_operand_a[W-1];
    b_neg   = is_sdiv && in_operand_b[W-1];
    special = (in_operand_b == '0) ||
              (is_sdiv && in_operand_a == wmdu_pkg::SIGN_BIT && in_operand_b == '1);
    ma_nxt  = a_neg ? (W'(0) - in_operand_a) : in_operand_a;
    // The signed product subtracts each operand whose partner is negative.
    corr_nxt = ((is_muls && in_operand_a[W-1]) ? in_operand_b : '0) +
               ((is_muls && in_operand_b[W-1]) ? in_operand_a : '0);
    if (special) begin
      mb_nxt = W'(1);
    end else begin
      mb_nxt = b_neg ? (W'(0) - in_operand_b) : in_operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_div_r        <= is_div;
      s0_negq_r       <= a_neg ^ (b_neg && !special);
      s0_negr_r       <= a_neg;
      s0_corr_r       <= corr_nxt;
      s0_ma_r         <= ma_nxt;
      s0_mb_r         <= mb_nxt;
      s0_p00_r <= W'(in_operand_a[H-1:0]) * W'(in_operand_b[H-1:0]);
      s0_p01_r <= W'(in_operand_a[H-1:0]) * W'(in_operand_b[W-1:H]);
      s0_p10_r <= W'(in_operand_a[W-1:H]) * W'(in_operand_b[H-1:0]);
      s0_p11_r <= W'(in_operand_a[W-1:H]) * W'(in_operand_b[W-1:H]);
    end
  end

  // Divide stage arrays; entry 0 is loaded by the product-sum stage.
  logic         st_vld_r  [0:Steps];
  logic         st_div_r  [0:Steps];
  logic         st_negq_r [0:Steps];
  logic         st_negr_r [0:Steps];
  logic [W-1:0] st_d_r    [0:Steps];
  logic [W-1:0] st_rem_r  [0:Steps];
  logic [W-1:0] st_q_r    [0:Steps];

  // Stage 1: product sum with signed correction, or divide setup.
  logic [H+1:0] mid;
  logic [W-1:0] prod_lo, prod_hi;

  always_comb begin
    mid = (H+2)'(s0_p00_r[W-1:H]) + (H+2)'(s0_p01_r[H-1:0]) + (H+2)'(s0_p10_r[H-1:0]);
    prod_lo = {mid[H-1:0], s0_p00_r[H-1:0]};
    prod_hi = s0_p11_r + W'(s0_p01_r[W-1:H]) + W'(s0_p10_r[W-1:H]) + W'(mid[H+1:H])
              - s0_corr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else if (adv) begin
      st_vld_r[0] <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_div_r[0]  <= s0_div_r;
      st_negq_r[0] <= s0_negq_r;
      st_negr_r[0] <= s0_negr_r;
      st_d_r[0]    <= s0_mb_r;
      st_rem_r[0]  <= s0_div_r ? '0 : prod_hi;
      st_q_r[0]    <= s0_div_r ? s0_ma_r : prod_lo;
    end
  end

  // One quotient bit per stage; multiply results pass through untouched.
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [W:0]   part;
    logic [W:0]   diff;
    logic         take;

    always_comb begin
      part = {st_rem_r[k], st_q_r[k][W-1]};
      diff = part - {1'b0, st_d_r[k]};
      take = !diff[W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        st_vld_r[k+1] <= st_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_div_r[k+1]  <= st_div_r[k];
        st_negq_r[k+1] <= st_negq_r[k];
        st_negr_r[k+1] <= st_negr_r[k];
        st_d_r[k+1]    <= st_d_r[k];
        if (st_div_r[k]) begin
          st_rem_r[k+1] <= take ? diff[W-1:0] : part[W-1:0];
          st_q_r[k+1]   <= {st_q_r[k][W-2:0], take};
        end else begin
          st_rem_r[k+1] <= st_rem_r[k];
          st_q_r[k+1]   <= st_q_r[k];
        end
      end
    end
  end

  // Output register with sign fix for signed divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_vld_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lo_r <= (st_div_r[Steps] && st_negq_r[Steps]) ?
                  (W'(0) - st_q_r[Steps]) : st_q_r[Steps];
      out_hi_r <= (st_div_r[Steps] && st_negr_r[Steps]) ?
                  (W'(0) - st_rem_r[Steps]) : st_rem_r[Steps];
    end
  end

  `WMDU_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid)
  `WMDU_ASSERT(a_stall_only_when_full, in_stall == (out_valid_r && out_stall))
  `WMDU_ASSERT(a_last_stage_holds, !$past(adv) |-> $stable(st_vld_r[Steps]))
  `WMDU_ASSERT(a_result_from_pipe, $rose(out_valid) |-> $past(st_vld_r[Steps]))
endmodule

// ===== sim/wide_multiply_divide_unit_tb.sv =====
// Testbench for the 64-bit multiply/divide unit: random and corner items against a predictor.
module wide_multiply_divide_unit_tb;

  typedef struct packed {
    logic [wmdu_pkg::KindW-1:0] kind;
    logic [wmdu_pkg::DataW-1:0] a;
    logic [wmdu_pkg::DataW-1:0] b;
  } op_item_t;

  typedef struct packed {
    logic [wmdu_pkg::DataW-1:0] lo;
    logic [wmdu_pkg::DataW-1:0] hi;
  } mdu_result_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [wmdu_pkg::KindW-1:0] in_kind;
  logic [wmdu_pkg::DataW-1:0] in_operand_a;
  logic [wmdu_pkg::DataW-1:0] in_operand_b;
  logic out_valid;
  logic out_stall;
  logic [wmdu_pkg::DataW-1:0] out_low_word;
  logic [wmdu_pkg::DataW-1:0] out_high_word;

  op_item_t pending_ops[$];
  mdu_result_t expected_results[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit stimulus_done;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned hold_left;
  bit hold_done;
  bit in_accepted;

  wide_multiply_divide_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mdu_result_t compute_mdu(op_item_t op);
    mdu_result_t r;
    logic [2*wmdu_pkg::DataW-1:0] prod;
    logic [wmdu_pkg::DataW-1:0] ma, mb, q, rem;
    logic a_neg, b_neg;
    a_neg = op.a[wmdu_pkg::DataW-1];
    b_neg = op.b[wmdu_pkg::DataW-1];
    case (op.kind)
      wmdu_pkg::KIND_MULU, wmdu_pkg::KIND_MULS: begin
        prod = {{wmdu_pkg::DataW{1'b0}}, op.a} * {{wmdu_pkg::DataW{1'b0}}, op.b};
        r.lo = prod[wmdu_pkg::DataW-1:0];
        r.hi = prod[2*wmdu_pkg::DataW-1:wmdu_pkg::DataW];
        if (op.kind == wmdu_pkg::KIND_MULS) begin
          if (a_neg) r.hi = r.hi - op.b;
          if (b_neg) r.hi = r.hi - op.a;
        end
      end
      wmdu_pkg::KIND_DIVU: begin
        mb = (op.b == '0) ? 64'd1 : op.b;
        r.lo = op.a / mb;
        r.hi = op.a % mb;
      end
      default: begin
        if (op.b == '0 || (op.a == wmdu_pkg::SIGN_BIT && op.b == '1)) begin
          r.lo = op.a;
          r.hi = '0;
        end else begin
          ma = a_neg ? -op.a : op.a;
          mb = b_neg ? -op.b : op.b;
          q = ma / mb;
          rem = ma % mb;
          r.lo = (a_neg != b_neg) ? -q : q;
          r.hi = a_neg ? -rem : rem;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [wmdu_pkg::DataW-1:0] rand_operand();
    logic [wmdu_pkg::DataW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = wmdu_pkg::SIGN_BIT;
      3: v = ~wmdu_pkg::SIGN_BIT;
      4: v = v >> $urandom_range(1, 63);
      5: v = -(v >> $urandom_range(1, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_op(logic [wmdu_pkg::KindW-1:0] k, logic [wmdu_pkg::DataW-1:0] a,
                        logic [wmdu_pkg::DataW-1:0] b);
    op_item_t op;
    op.kind = k;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [wmdu_pkg::KindW-1:0] kinds[4];
    kinds = '{wmdu_pkg::KIND_MULU, wmdu_pkg::KIND_MULS, wmdu_pkg::KIND_DIVS,
              wmdu_pkg::KIND_DIVU};
    foreach (kinds[i]) begin
      add_op(kinds[i], '1, '1);
      add_op(kinds[i], wmdu_pkg::SIGN_BIT, '1);
      add_op(kinds[i], 64'd12345, '0);
      add_op(kinds[i], -64'd7, 64'd2);
      add_op(kinds[i], 64'd7, -64'd2);
    end
    add_op(wmdu_pkg::KIND_DIVS, '0, '0);
    add_op(wmdu_pkg::KIND_MULS, wmdu_pkg::SIGN_BIT, wmdu_pkg::SIGN_BIT);
    add_op(wmdu_pkg::KIND_DIVS, wmdu_pkg::SIGN_BIT, 64'd1);
    for (int i = 0; i < 1200; i++) begin
      add_op(wmdu_pkg::KindW'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
  end

  // Records whether the input item was taken at the last rising edge.
  always @(posedge clk) begin
    in_accepted <= in_valid && !in_stall;
  end

  // Driver: a new item is presented at the falling edge once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_accepted) begin
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_ops.size() != 0) begin
        in_valid <= 1'b1;
        in_kind <= pending_ops[0].kind;
        in_operand_a <= pending_ops[0].a;
        in_operand_b <= pending_ops[0].b;
        expected_results.push_back(compute_mdu(pending_ops[0]));
        void'(pending_ops.pop_front());
        send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random waits, plus one long hold-off to back up the pipeline.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && expected_results.size() > 10) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && $urandom_range(0, 1) == 0) recv_wait <= $urandom_range(0, 7);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    mdu_result_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result lo=%h hi=%h", $time, out_low_word, out_high_word);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_low_word !== exp_r.lo) begin
            $display("%0t: low_word expected %h actual %h", $time, exp_r.lo, out_low_word);
            error_count++;
          end
          if (out_high_word !== exp_r.hi) begin
            $display("%0t: high_word expected %h actual %h", $time, exp_r.hi, out_high_word);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        // Expected results are queued when an item is presented, so also wait for acceptance.
        wait (pending_ops.size() == 0);
        @(posedge clk);
        while (in_valid) @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0) $display("wide_multiply_divide_unit regression: pass");
        else $display("wide_multiply_divide_unit regression: fail");
      end
      begin
        wait (idle_cycles >= WatchdogLimit);
        $display("wide_multiply_divide_unit regression: fail");
      end
    join_any
    $finish;
  end
endmodule
